>>> sv/ulb_pkg.sv
// Shared types, constants and helpers for the uop cache line builder.
package ulb_pkg;

  localparam int unsigned ADDR_BITS      = 48;
  localparam int unsigned OFF_BITS       = 12;
  localparam int unsigned SIZE_BITS      = 4;
  localparam int unsigned MAX_LINE_WIDTH = 16;
  localparam int unsigned CNT_BITS       = 5;
  localparam int unsigned QUEUE_DEPTH    = 2;
  localparam int unsigned QPTR_BITS      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCNT_BITS      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CNT_BITS-1:0] WIDTH_RESET = CNT_BITS'(6);
  localparam logic [CNT_BITS-1:0] WIDTH_MAX   = CNT_BITS'(MAX_LINE_WIDTH);
  localparam logic [CNT_BITS-1:0] WIDTH_MIN   = CNT_BITS'(1);
  localparam logic [OFF_BITS-1:0] OFFSET_MAX  = '1;

  typedef logic [ADDR_BITS-1:0] addr_t;
  typedef logic [CNT_BITS-1:0]  cnt_t;
  typedef logic [OFF_BITS-1:0]  off_t;

  // Flags bit 0 is off-path, bit 1 is fake-nop.
  typedef logic [1:0] flags_t;

  typedef struct packed {
    addr_t                 op_addr;
    logic [SIZE_BITS-1:0]  op_size;
    logic                  end_of_macro;
    logic                  last_op;
    addr_t                 tgt_start;
    logic [OFF_BITS-1:0]   tgt_len;
    logic                  tgt_off_path;
    logic                  ft_fake_nop;
  } ulb_in_t;

  typedef struct packed {
    addr_t  line_addr;
    cnt_t   uop_count;
    off_t   next_offset;
    logic   ends_target;
    logic   line_off_path;
    logic   line_fake_nop;
    logic   last_of_step;
  } ulb_out_t;

  // Everything one accepted uop leaves for the back end: an optional held
  // full line and an optional closing line of the current fetch target.
  typedef struct packed {
    logic   held_v;
    addr_t  held_start;
    cnt_t   held_count;
    flags_t held_flags;
    addr_t  next_addr;
    logic   open_v;
    logic   open_zero;
    addr_t  open_start;
    cnt_t   open_count;
    flags_t open_flags;
    addr_t  open_end;
  } ulb_step_t;

  // Address difference modulo 2^ADDR_BITS, saturated to the offset width.
  function automatic off_t sat_offset(input addr_t to_addr, input addr_t from_addr);
    addr_t diff;
    diff = to_addr - from_addr;
    if (|diff[ADDR_BITS-1:OFF_BITS]) begin
      return OFFSET_MAX;
    end
    return diff[OFF_BITS-1:0];
  endfunction

endpackage

>>> sv/uop_cache_line_builder_top.sv
// Top level of the uop cache line builder.
// The builder packs the uops of a fetch target into line records of up to
// line_width uops (0 acts as 1, above 16 acts as 16). It accepts one uop per
// cycle: a uop is taken whenever the two-entry step queue has room. Each uop
// leaves zero, one or two records, and records leave through a registered
// output at one per cycle while out_ready_i is high, so a uop that both
// releases a held full line and closes its own line sends the held line first
// and its own line after it. A full line is emitted only when the next uop
// arrives, since its offset depends on that uop's address. The line_width register
// may be written at any time the block is idle; writes are always accepted.
module uop_cache_line_builder_top
  import ulb_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  ulb_in_t   in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output ulb_out_t  out_data_o,
  input  logic      cfg_valid_i,
  output logic      cfg_ready_o,
  input  cnt_t      cfg_data_i
);

  logic      push_valid;
  logic      push_ready;
  ulb_step_t push_data;
  logic      pop_valid;
  logic      pop;
  ulb_step_t pop_data;

  assign cfg_ready_o = 1'b1;

  ulb_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_data_i    (in_data_i),
    .cfg_valid_i  (cfg_valid_i && cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  ulb_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_i        (pop),
    .pop_data_o   (pop_data)
  );

  ulb_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_o       (pop),
    .pop_data_i  (pop_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // Every emitted line holds at least one uop and never more than the maximum.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.uop_count != '0) && (out_data_o.uop_count <= WIDTH_MAX))
    else $error("line record with invalid uop count");

  // A line that ends its fetch target is always the final record of its step.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.ends_target |-> out_data_o.last_of_step)
    else $error("target-ending line not marked last of step");

  // A held line record is always followed by another record of the same step
  // or is itself the last one; it never carries the target-end flag.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.last_of_step |-> !out_data_o.ends_target)
    else $error("non-final record marked as ending the target");

  // Popping the queue requires an entry to be present.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> pop_valid)
    else $error("queue popped while empty");

endmodule

>>> sv/ulb_front.sv
// Front end: accepts uops, tracks the open and held lines, and classifies closures.
module ulb_front
  import ulb_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  ulb_in_t         in_data_i,
  input  logic            cfg_valid_i,
  input  cnt_t            cfg_data_i,
  output logic            push_valid_o,
  input  logic            push_ready_i,
  output ulb_step_t       push_data_o
);

  cnt_t   width_q;
  logic   open_valid_q, open_valid_d;
  addr_t  open_start_q, open_start_d;
  cnt_t   open_count_q, open_count_d;
  flags_t open_flags_q, open_flags_d;
  logic   held_valid_q, held_valid_d;
  addr_t  held_start_q, held_start_d;
  cnt_t   held_count_q, held_count_d;
  flags_t held_flags_q, held_flags_d;

  logic   accept;
  cnt_t   eff_width;
  addr_t  cur_start;
  flags_t cur_flags;
  cnt_t   cur_count;
  addr_t  inst_end;
  addr_t  ft_end;
  logic   ft_done;
  logic   full;

  assign in_ready_o = push_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    if (width_q == '0) begin
      eff_width = WIDTH_MIN;
    end else if (width_q > WIDTH_MAX) begin
      eff_width = WIDTH_MAX;
    end else begin
      eff_width = width_q;
    end
  end

  assign cur_start = open_valid_q ? open_start_q : in_data_i.op_addr;
  assign cur_flags = open_valid_q ? open_flags_q
                                  : {in_data_i.ft_fake_nop, in_data_i.tgt_off_path};
  // The open count is kept at zero whenever no line is open.
  assign cur_count = open_count_q + CNT_BITS'(1);
  assign inst_end  = in_data_i.op_addr + ADDR_BITS'(in_data_i.op_size);
  assign ft_end    = in_data_i.tgt_start + ADDR_BITS'(in_data_i.tgt_len);
  assign ft_done   = in_data_i.end_of_macro && (inst_end == ft_end);
  assign full      = cur_count >= eff_width;

  always_comb begin
    push_data_o.held_v     = held_valid_q;
    push_data_o.held_start = held_start_q;
    push_data_o.held_count = held_count_q;
    push_data_o.held_flags = held_flags_q;
    push_data_o.next_addr  = in_data_i.op_addr;
    push_data_o.open_v     = ft_done || in_data_i.last_op;
    push_data_o.open_zero  = ft_done;
    push_data_o.open_start = cur_start;
    push_data_o.open_count = cur_count;
    push_data_o.open_flags = cur_flags;
    push_data_o.open_end   = inst_end;
    push_valid_o = accept && (held_valid_q || ft_done || in_data_i.last_op);
  end

  always_comb begin
    open_valid_d = open_valid_q;
    open_start_d = open_start_q;
    open_count_d = open_count_q;
    open_flags_d = open_flags_q;
    held_valid_d = held_valid_q;
    held_start_d = held_start_q;
    held_count_d = held_count_q;
    held_flags_d = held_flags_q;
    if (accept) begin
      held_valid_d = 1'b0;
      if (ft_done || in_data_i.last_op) begin
        open_valid_d = 1'b0;
        open_count_d = '0;
      end else if (full) begin
        // A full line waits for the next uop to learn its offset.
        held_valid_d = 1'b1;
        held_start_d = cur_start;
        held_count_d = cur_count;
        held_flags_d = cur_flags;
        open_valid_d = 1'b0;
        open_count_d = '0;
      end else begin
        open_valid_d = 1'b1;
        open_start_d = cur_start;
        open_count_d = cur_count;
        open_flags_d = cur_flags;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q      <= WIDTH_RESET;
      open_valid_q <= 1'b0;
      open_count_q <= '0;
      open_flags_q <= '0;
      held_valid_q <= 1'b0;
      held_count_q <= '0;
      held_flags_q <= '0;
    end else begin
      if (cfg_valid_i) begin
        width_q <= cfg_data_i;
      end
      open_valid_q <= open_valid_d;
      open_count_q <= open_count_d;
      open_flags_q <= open_flags_d;
      held_valid_q <= held_valid_d;
      held_count_q <= held_count_d;
      held_flags_q <= held_flags_d;
    end
  end

  always_ff @(posedge clk_i) begin
    open_start_q <= open_start_d;
    held_start_q <= held_start_d;
  end

endmodule

>>> sv/ulb_queue.sv
// Short register queue of step results between the front and back ends.
module ulb_queue
  import ulb_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_valid_i,
  output logic       push_ready_o,
  input  ulb_step_t  push_data_i,
  output logic       pop_valid_o,
  input  logic       pop_i,
  output ulb_step_t  pop_data_o
);

  ulb_step_t              entries_q [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0]   wr_ptr_q, wr_ptr_d;
  logic [QPTR_BITS-1:0]   rd_ptr_q, rd_ptr_d;
  logic [QCNT_BITS-1:0]   count_q, count_d;
  logic                   do_push;
  logic                   do_pop;

  localparam logic [QCNT_BITS-1:0] DEPTH_CNT = QCNT_BITS'(QUEUE_DEPTH);
  localparam logic [QPTR_BITS-1:0] LAST_PTR  = QPTR_BITS'(QUEUE_DEPTH - 1);

  assign push_ready_o = count_q != DEPTH_CNT;
  assign pop_valid_o  = count_q != '0;
  assign pop_data_o   = entries_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + QPTR_BITS'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + QPTR_BITS'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + QCNT_BITS'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - QCNT_BITS'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

>>> sv/ulb_back.sv
// Back end: turns queued step results into line records and drives the output register.
module ulb_back
  import ulb_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       pop_valid_i,
  output logic       pop_o,
  input  ulb_step_t  pop_data_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output ulb_out_t   out_data_o
);

  logic     phase_q, phase_d;
  logic     out_valid_q, out_valid_d;
  ulb_out_t out_q, out_d;
  logic     emit_held;
  logic     load;
  addr_t    off_to;
  addr_t    off_from;
  off_t     offset;

  // The held line of a step goes out before the step's own closing line.
  assign emit_held = pop_data_i.held_v && !phase_q;
  assign load      = pop_valid_i && (!out_valid_q || out_ready_i);
  assign off_to    = emit_held ? pop_data_i.next_addr  : pop_data_i.open_end;
  assign off_from  = emit_held ? pop_data_i.held_start : pop_data_i.open_start;

  always_comb begin
    if (!emit_held && pop_data_i.open_zero) begin
      offset = '0;
    end else begin
      offset = sat_offset(off_to, off_from);
    end
  end

  always_comb begin
    out_d.line_addr     = emit_held ? pop_data_i.held_start    : pop_data_i.open_start;
    out_d.uop_count     = emit_held ? pop_data_i.held_count    : pop_data_i.open_count;
    out_d.next_offset   = offset;
    out_d.ends_target   = !emit_held;
    out_d.line_off_path = emit_held ? pop_data_i.held_flags[0] : pop_data_i.open_flags[0];
    out_d.line_fake_nop = emit_held ? pop_data_i.held_flags[1] : pop_data_i.open_flags[1];
    out_d.last_of_step  = !emit_held || !pop_data_i.open_v;

    phase_d     = phase_q;
    out_valid_d = out_valid_q;
    pop_o       = 1'b0;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (load) begin
      out_valid_d = 1'b1;
      if (emit_held && pop_data_i.open_v) begin
        phase_d = 1'b1;
      end else begin
        phase_d = 1'b0;
        pop_o   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
